// File: hdl/assert_macros.svh
// Assertion helpers included by text_console_char_writer.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// File: hdl/tcw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text console character writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry.
  localparam int WIDTH_DEF  = 80;
  localparam int HEIGHT_DEF = 25;

  // Field widths of the command and result transactions.
  localparam int MODE_W   = 2;
  localparam int CH_W     = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int IDX_W    = 11;
  localparam int CURPOS_W = 11;

  // Control bytes and fill letter.
  localparam logic [CH_W-1:0] KEY_NEWLINE   = 8'd10;
  localparam logic [CH_W-1:0] KEY_BACKSPACE = 8'd8;
  localparam logic [CH_W-1:0] KEY_TAB       = 8'd9;
  localparam logic [CH_W-1:0] BLANK         = 8'd32;
  localparam int              TAB_STEP      = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT        = 2'd0,
    MODE_SET_CURSOR = 2'd1,
    MODE_CLEAR      = 2'd2,
    MODE_READ       = 2'd3
  } mode_e;

endpackage

// File: hdl/tcw_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcw_cmd_if / tcw_rsp_if
// Valid/ready channels for console commands and their results.
// ---------------------------------------------------------------------------
interface tcw_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::MODE_W-1:0]   mode;
  logic [tcw_pkg::CH_W-1:0]     ch;
  logic [tcw_pkg::COL_W-1:0]    col;
  logic [tcw_pkg::ROW_W-1:0]    row;
  logic [tcw_pkg::IDX_W-1:0]    cell_index;

  modport source (output valid, mode, ch, col, row, cell_index, input ready);
  modport sink   (input valid, mode, ch, col, row, cell_index, output ready);
endinterface

interface tcw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::CURPOS_W-1:0]  cursor_pos;
  logic [tcw_pkg::CH_W-1:0]      letter;
  logic                          scrolled;

  modport source (output valid, cursor_pos, letter, scrolled, input ready);
  modport sink   (input valid, cursor_pos, letter, scrolled, output ready);
endinterface

// File: hdl/text_console_char_writer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_char_writer
// Text-mode screen store with a linear cursor and scroll-up on overflow.
// ---------------------------------------------------------------------------
// Usage: cmd_i carries one command per transaction (put character, set
// cursor, clear screen, read cell); rsp_o returns exactly one result per
// command: the cursor after it, the letter read, and a scroll flag.
// The letter store is a single-port-write, single-port-read synchronous
// memory of WIDTH*HEIGHT bytes; its contents are undefined after reset, so
// software clears the screen before the first read.
// Timing: put character and set cursor finish in the accept cycle, so a new
// command can be taken every cycle while no result is stalled. Read cell
// passes through the memory read register and then the output register.
// Clear screen writes one cell per cycle. A put that scrolls reads every
// cell one row further down and writes it back, one cell per cycle through
// the memory ports, the bottom row being filled with spaces.
// Reset clears the cursor and the control state only.
// A stalled result stays in the output register; the next command is
// accepted in that same cycle in which the pending result is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_char_writer #(
  parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
  parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tcw_cmd_if.sink  cmd_i,
  tcw_rsp_if.source rsp_o
);

  localparam int NCELLS = WIDTH * HEIGHT;
  localparam int AW     = $clog2(NCELLS);
  localparam int CW     = $clog2(NCELLS + WIDTH + tcw_pkg::TAB_STEP);
  localparam int CLW    = $clog2(WIDTH);
  localparam int RW     = $clog2(HEIGHT);

  localparam logic [CW-1:0]  NCELLS_C   = CW'(NCELLS);
  localparam logic [CW-1:0]  WIDTH_C    = CW'(WIDTH);
  localparam logic [CW-1:0]  LAST_ROW_C = CW'((HEIGHT - 1) * WIDTH);
  localparam logic [AW-1:0]  LAST_CELL  = AW'(NCELLS - 1);
  localparam logic [AW-1:0]  MOVE_END   = AW'(NCELLS - WIDTH);
  localparam logic [CLW-1:0] LAST_COL   = CLW'(WIDTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_RESP
  } state_e;

  state_e                      state_q;
  logic [CW-1:0]               cursor_q;
  logic [CLW-1:0]              col_q;
  logic [AW-1:0]               sweep_q;
  logic                        pend_valid_q;
  logic [AW-1:0]               pend_addr_q;
  logic                        pend_move_q;
  logic                        is_read_q;
  logic                        oob_q;
  logic                        scrolled_q;
  logic                        out_valid_q;
  logic [tcw_pkg::CURPOS_W-1:0] out_cursor_q;
  logic [tcw_pkg::CH_W-1:0]    out_letter_q;
  logic                        out_scrolled_q;

  logic [tcw_pkg::CH_W-1:0]    cell_mem [NCELLS];
  logic [tcw_pkg::CH_W-1:0]    rdata_q;

  logic                        out_free;
  logic                        accept;
  tcw_pkg::mode_e              mode;
  logic                        is_nl, is_bs, is_tab;
  logic [3:0]                  tab_step;
  logic [CLW:0]                col_tab;
  logic [CW-1:0]               put_cursor;
  logic [CLW-1:0]              put_col;
  logic                        put_write;
  logic                        put_scroll;
  logic [CLW-1:0]              col_sat;
  logic [RW-1:0]               row_sat;
  logic [CW-1:0]               set_pos;
  logic                        read_oob;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [tcw_pkg::CH_W-1:0]    mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign mode        = tcw_pkg::mode_e'(cmd_i.mode);

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.cursor_pos = out_cursor_q;
  assign rsp_o.letter     = out_letter_q;
  assign rsp_o.scrolled   = out_scrolled_q;

  // Put-character cursor arithmetic. The column is tracked alongside the
  // linear cursor so that newline and wrap need no division.
  always_comb begin
    is_nl    = (cmd_i.ch == tcw_pkg::KEY_NEWLINE);
    is_bs    = (cmd_i.ch == tcw_pkg::KEY_BACKSPACE);
    is_tab   = (cmd_i.ch == tcw_pkg::KEY_TAB);
    tab_step = 4'(tcw_pkg::TAB_STEP) - {1'b0, cursor_q[2:0]};
    col_tab  = {1'b0, col_q} + (CLW + 1)'(tab_step);
    if (col_tab >= (CLW + 1)'(WIDTH)) begin
      col_tab = col_tab - (CLW + 1)'(WIDTH);
    end

    put_write = 1'b0;
    if (is_nl) begin
      put_cursor = cursor_q + WIDTH_C - CW'(col_q);
      put_col    = '0;
    end else if (is_bs) begin
      put_cursor = (cursor_q == '0) ? cursor_q : cursor_q - CW'(1);
      put_col    = (cursor_q == '0) ? col_q :
                   ((col_q == '0) ? LAST_COL : col_q - CLW'(1));
      put_write  = (cursor_q != '0);
    end else if (is_tab) begin
      put_cursor = cursor_q + CW'(tab_step);
      put_col    = col_tab[CLW-1:0];
    end else begin
      put_cursor = cursor_q + CW'(1);
      put_col    = (col_q == LAST_COL) ? '0 : col_q + CLW'(1);
      put_write  = 1'b1;
    end
    put_scroll = (put_cursor >= NCELLS_C);

    col_sat    = (32'(cmd_i.col) > 32'(WIDTH - 1)) ? LAST_COL : CLW'(cmd_i.col);
    row_sat    = (32'(cmd_i.row) > 32'(HEIGHT - 1)) ? RW'(HEIGHT - 1) : RW'(cmd_i.row);
    set_pos    = CW'(row_sat) * WIDTH_C + CW'(col_sat);
    read_oob   = (32'(cmd_i.cell_index) >= 32'(NCELLS));
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cursor_q[AW-1:0];
    mem_wdata = cmd_i.ch;
    mem_re    = 1'b0;
    mem_raddr = AW'(cmd_i.cell_index);
    if (accept && mode == tcw_pkg::MODE_PUT && put_write) begin
      mem_we = 1'b1;
      if (is_bs) begin
        mem_waddr = put_cursor[AW-1:0];
        mem_wdata = tcw_pkg::BLANK;
      end
    end else if (pend_valid_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = pend_move_q ? rdata_q : tcw_pkg::BLANK;
    end else if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_q;
      mem_wdata = tcw_pkg::BLANK;
    end
    if (accept && mode == tcw_pkg::MODE_READ) begin
      mem_re = 1'b1;
    end else if (state_q == ST_SCROLL) begin
      // Source cell one row below; wraps harmlessly on the blank bottom row.
      mem_re    = 1'b1;
      mem_raddr = AW'({1'b0, sweep_q} + (AW + 1)'(WIDTH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= cell_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cursor_q       <= '0;
      col_q          <= '0;
      sweep_q        <= '0;
      pend_valid_q   <= 1'b0;
      pend_addr_q    <= '0;
      pend_move_q    <= 1'b0;
      is_read_q      <= 1'b0;
      oob_q          <= 1'b0;
      scrolled_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      out_cursor_q   <= '0;
      out_letter_q   <= '0;
      out_scrolled_q <= 1'b0;
    end else begin
      if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      pend_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            is_read_q  <= 1'b0;
            scrolled_q <= 1'b0;
            sweep_q    <= '0;
            case (mode)
              tcw_pkg::MODE_PUT: begin
                if (put_scroll) begin
                  cursor_q   <= LAST_ROW_C;
                  col_q      <= '0;
                  scrolled_q <= 1'b1;
                  state_q    <= ST_SCROLL;
                end else begin
                  cursor_q       <= put_cursor;
                  col_q          <= put_col;
                  out_valid_q    <= 1'b1;
                  out_cursor_q   <= tcw_pkg::CURPOS_W'(put_cursor);
                  out_letter_q   <= '0;
                  out_scrolled_q <= 1'b0;
                end
              end
              tcw_pkg::MODE_SET_CURSOR: begin
                cursor_q       <= set_pos;
                col_q          <= col_sat;
                out_valid_q    <= 1'b1;
                out_cursor_q   <= tcw_pkg::CURPOS_W'(set_pos);
                out_letter_q   <= '0;
                out_scrolled_q <= 1'b0;
              end
              tcw_pkg::MODE_CLEAR: begin
                cursor_q <= '0;
                col_q    <= '0;
                state_q  <= ST_CLEAR;
              end
              tcw_pkg::MODE_READ: begin
                is_read_q <= 1'b1;
                oob_q     <= read_oob;
                state_q   <= ST_RESP;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SCROLL: begin
          // Read issued now is written back in the next cycle, one row up.
          pend_valid_q <= 1'b1;
          pend_addr_q  <= sweep_q;
          pend_move_q  <= (sweep_q < MOVE_END);
          sweep_q      <= sweep_q + AW'(1);
          if (sweep_q == LAST_CELL) begin
            state_q <= ST_RESP;
          end
        end
        ST_CLEAR: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_q == LAST_CELL) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            out_cursor_q   <= tcw_pkg::CURPOS_W'(cursor_q);
            out_letter_q   <= (is_read_q && !oob_q) ? rdata_q : '0;
            out_scrolled_q <= scrolled_q;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A command never overlaps an outstanding write-back of the scroll sweep.
  `ASSERT_NEVER(a_no_accept_with_pending, clk_i, rst_ni, accept && pend_valid_q)
  // Between commands the cursor always lies on the screen.
  `ASSERT_CLK(a_cursor_on_screen, clk_i, rst_ni,
              (state_q == ST_IDLE) |-> (cursor_q < NCELLS_C && col_q <= LAST_COL))
  // A scroll leaves the cursor at the start of the bottom row.
  `ASSERT_CLK(a_scroll_cursor, clk_i, rst_ni,
              (out_valid_q && out_scrolled_q) |->
                (out_cursor_q == tcw_pkg::CURPOS_W'(LAST_ROW_C)))
  // The last scroll write-back lands in the response cycle.
  `ASSERT_CLK(a_sweep_done, clk_i, rst_ni,
              pend_valid_q |-> (state_q == ST_SCROLL || state_q == ST_RESP))

endmodule
